>>> sv/jaos_pkg.sv
// Shared types and constants for the JSON array object splitter.
package jaos_pkg;

	localparam int unsigned KEY_LEN = 6;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;

	// One result word's marks, plus whether the byte produces a result at all.
	typedef struct packed {
		logic emit;
		logic first;
		logic last;
		logic trunc;
	} jaos_res_t;

	// Expected byte of the "data" key (with its quotes) at match position idx.
	function automatic logic [7:0] key_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = CH_QUOTE;
			3'd1:    b = 8'h64;
			3'd2:    b = 8'h61;
			3'd3:    b = 8'h74;
			3'd4:    b = 8'h61;
			3'd5:    b = CH_QUOTE;
			default: b = CH_QUOTE;
		endcase
		return b;
	endfunction

endpackage

>>> sv/jaos_scan.sv
// Parser state and per-byte next-state logic of the object splitter.
module jaos_scan
	import jaos_pkg::*;
#(
	parameter int DEPTH_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_byte,
	input  logic       doc_last,
	output jaos_res_t  res
);

	localparam logic [1:0] PH_KEY  = 2'd0;
	localparam logic [1:0] PH_BRACK = 2'd1;
	localparam logic [1:0] PH_SCAN = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic signed [DEPTH_WIDTH-1:0] DMAX = {1'b0, {(DEPTH_WIDTH-1){1'b1}}};
	localparam logic signed [DEPTH_WIDTH-1:0] DMIN = {1'b1, {(DEPTH_WIDTH-1){1'b0}}};
	localparam logic signed [DEPTH_WIDTH-1:0] DONE = {{(DEPTH_WIDTH-1){1'b0}}, 1'b1};
	localparam logic signed [DEPTH_WIDTH-1:0] DZERO = '0;

	logic [1:0]                    phase_q, phase_d;
	logic [2:0]                    kmc_q, kmc_d, kmc_idx;
	logic                          instr_q, instr_d;
	logic                          esc_q, esc_d;
	logic                          open_q, open_d;
	logic signed [DEPTH_WIDTH-1:0] depth_q, depth_d;
	logic                          first, closing;

	always_comb begin
		phase_d = phase_q;
		kmc_d   = kmc_q;
		instr_d = instr_q;
		esc_d   = esc_q;
		open_d  = open_q;
		depth_d = depth_q;
		first   = 1'b0;
		closing = 1'b0;
		kmc_idx = (kmc_q >= 3'(KEY_LEN)) ? 3'd0 : kmc_q;

		unique case (phase_q)
			PH_KEY: begin
				if (char_byte == key_byte(kmc_idx)) begin
					if (kmc_idx == 3'(KEY_LEN - 1)) begin
						phase_d = PH_BRACK;
						kmc_d   = 3'd0;
					end else begin
						kmc_d = kmc_idx + 3'd1;
					end
				end else begin
					kmc_d = (char_byte == CH_QUOTE) ? 3'd1 : 3'd0;
				end
			end
			PH_BRACK: begin
				if (char_byte == CH_LBRACK)
					phase_d = PH_SCAN;
			end
			PH_SCAN: begin
				if (esc_q) begin
					esc_d = 1'b0;
				end else if (char_byte == CH_BSLASH && instr_q) begin
					esc_d = 1'b1;
				end else if (char_byte == CH_QUOTE) begin
					instr_d = !instr_q;
				end else if (!instr_q) begin
					if (char_byte == CH_LBRACE) begin
						if (depth_q == DZERO) begin
							open_d = 1'b1;
							first  = 1'b1;
						end
						if (depth_q != DMAX)
							depth_d = depth_q + DONE;
					end else if (char_byte == CH_RBRACE) begin
						if (depth_q != DMIN)
							depth_d = depth_q - DONE;
						if (depth_d == DZERO && open_q) begin
							closing = 1'b1;
							open_d  = 1'b0;
						end
					end else if (char_byte == CH_RBRACK && depth_q == DZERO) begin
						phase_d = PH_DONE;
					end
				end
			end
			PH_DONE: ;
			default: ;
		endcase

		res.emit  = (phase_q == PH_SCAN) && (open_q || first);
		res.first = first;
		res.last  = closing;
		res.trunc = doc_last && open_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			kmc_q   <= 3'd0;
			instr_q <= 1'b0;
			esc_q   <= 1'b0;
			open_q  <= 1'b0;
			depth_q <= DZERO;
		end else if (step) begin
			if (doc_last) begin
				phase_q <= PH_KEY;
				kmc_q   <= 3'd0;
				instr_q <= 1'b0;
				esc_q   <= 1'b0;
				open_q  <= 1'b0;
				depth_q <= DZERO;
			end else begin
				phase_q <= phase_d;
				kmc_q   <= kmc_d;
				instr_q <= instr_d;
				esc_q   <= esc_d;
				open_q  <= open_d;
				depth_q <= depth_d;
			end
		end
	end

	// An open object sits strictly inside the array scan.
	a_open_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (phase_q == PH_SCAN && depth_q > DZERO))
		else $error("object open outside array scan or at non-positive depth");

	// Escapes only arise inside strings.
	a_esc_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> instr_q)
		else $error("escape pending outside a string");

	// Key matcher never holds a full-length count.
	a_kmc_range: assert property (@(posedge clk) disable iff (!arst_n)
		kmc_q < 3'(KEY_LEN))
		else $error("key match count out of range");

endmodule

>>> sv/jaos_oreg.sv
// Result register driving the output channel.
module jaos_oreg
	import jaos_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [7:0] byte_in,
	input  jaos_res_t  res,
	output logic       free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] obj_byte,
	output logic       obj_first,
	output logic       obj_last,
	output logic       obj_truncated
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       first_q, last_q, trunc_q;

	// Register can take a new word when empty or when its word leaves now.
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			byte_q  <= byte_in;
			first_q <= res.first;
			last_q  <= res.last;
			trunc_q <= res.trunc;
		end
	end

	assign out_valid     = valid_q;
	assign obj_byte      = byte_q;
	assign obj_first     = first_q;
	assign obj_last      = last_q;
	assign obj_truncated = trunc_q;

endmodule

>>> sv/json_array_object_splitter_core.sv
// Top level of the JSON array object splitter: input register, parser, result register.
// An accepted word moves from the input register through the parser into the result register.
// Throughput: one byte per cycle while the output does not stall; the parser steps as each byte advances.
// Stall on the output backs up into the input register and then onto in_stall.
// Bytes that produce no result still take one slot in the input register.
// Reset (arst_n low) clears all parser state and both valid flags at once.
module json_array_object_splitter_core
	import jaos_pkg::*;
#(
	parameter int DEPTH_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_byte,
	input  logic       doc_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] obj_byte,
	output logic       obj_first,
	output logic       obj_last,
	output logic       obj_truncated
);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	jaos_res_t  res;
	logic       out_free;
	logic       advance;

	// The word in the input register moves on once the result register can
	// take it; words with no result still wait, which keeps the path simple.
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= char_byte;
			last_s1 <= doc_last;
		end
	end

	// Parser: key match, bracket search, string/escape/brace tracking
	jaos_scan #(
		.DEPTH_WIDTH(DEPTH_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_byte (byte_s1),
		.doc_last  (last_s1),
		.res       (res)
	);

	// Result register
	jaos_oreg u_oreg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res.emit),
		.byte_in       (byte_s1),
		.res           (res),
		.free          (out_free),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.obj_byte      (obj_byte),
		.obj_first     (obj_first),
		.obj_last      (obj_last),
		.obj_truncated (obj_truncated)
	);

	// An opening brace never also closes its object.
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(obj_first && obj_last))
		else $error("word marked both first and last");

	// Input only stalls when a word is actually held.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A word leaves the input register only into a free result register.
	a_advance_free: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && out_stall) |=> valid_s1 && $stable(byte_s1))
		else $error("input word lost while output stalled");

endmodule

>>> sim/json_array_object_splitter_core_tb.sv
// Self-checking testbench for json_array_object_splitter_core: random JSON documents vs. a predictor.
`timescale 1ns / 100ps

import jaos_pkg::*;

localparam int DEPTH_WIDTH = 8;
localparam int DEPTH_HI = 2 ** (DEPTH_WIDTH - 1) - 1;
localparam int DEPTH_LO = -(2 ** (DEPTH_WIDTH - 1));

// "data" key with its quotes, first byte in the top bits
localparam logic [8*KEY_LEN-1:0] DATA_KEY = {CH_QUOTE, 8'h64, 8'h61, 8'h74, 8'h61, CH_QUOTE};

typedef enum logic [1:0] {
	SEEK_KEY,
	SEEK_BRACKET,
	SCAN_ARRAY,
	SCAN_DONE
} scan_phase_e;

typedef struct packed {
	logic [7:0] obj_byte;
	logic       first;
	logic       last;
	logic       trunc;
} obj_word_t;

// Tracks the parser state per accepted word and holds the object words still due.
class splitter_scoreboard;
	scan_phase_e                   phase;
	logic [2:0]                    key_pos;
	logic                          in_str;
	logic                          esc;
	logic                          obj_open;
	logic signed [DEPTH_WIDTH-1:0] depth;
	obj_word_t                     expected_q[$];
	int unsigned                   errors;
	int unsigned                   accepted;

	function new();
		errors = 0;
		accepted = 0;
		clear_state();
	endfunction

	function void clear_state();
		phase = SEEK_KEY;
		key_pos = 3'd0;
		in_str = 1'b0;
		esc = 1'b0;
		obj_open = 1'b0;
		depth = '0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void note_word(logic [7:0] b, logic is_last);
		obj_word_t w;
		logic emit;
		w = '{obj_byte: b, first: 1'b0, last: 1'b0, trunc: 1'b0};
		emit = 1'b0;
		accepted++;
		case (phase)
			SEEK_KEY: begin
				if (b == DATA_KEY[8 * (KEY_LEN - 1 - key_pos) +: 8]) begin
					if (key_pos == KEY_LEN - 1) begin
						phase = SEEK_BRACKET;
						key_pos = 3'd0;
					end else
						key_pos = key_pos + 3'd1;
				end else
					key_pos = (b == CH_QUOTE) ? 3'd1 : 3'd0;
			end
			SEEK_BRACKET: begin
				if (b == CH_LBRACK)
					phase = SCAN_ARRAY;
			end
			SCAN_ARRAY: begin
				emit = obj_open;
				if (esc)
					esc = 1'b0;
				else if (b == CH_BSLASH && in_str)
					esc = 1'b1;
				else if (b == CH_QUOTE)
					in_str = !in_str;
				else if (!in_str) begin
					if (b == CH_LBRACE) begin
						if (depth == 0) begin
							obj_open = 1'b1;
							w.first = 1'b1;
							emit = 1'b1;
						end
						if (depth < DEPTH_HI)
							depth++;
					end else if (b == CH_RBRACE) begin
						if (depth > DEPTH_LO)
							depth--;
						if (depth == 0 && obj_open) begin
							w.last = 1'b1;
							obj_open = 1'b0;
						end
					end else if (b == CH_RBRACK && depth == 0)
						phase = SCAN_DONE;
				end
			end
			default: ;
		endcase
		w.trunc = is_last && obj_open;
		if (is_last)
			clear_state();
		if (emit)
			expected_q = {expected_q, w};
	endfunction

	function void check_result(logic [7:0] b, logic f, logic l, logic t);
		obj_word_t w;
		if (expected_q.size() == 0) begin
			$error("unexpected result word: obj_byte %02h", b);
			errors++;
			return;
		end
		w = expected_q.pop_front();
		if (b !== w.obj_byte) begin
			$error("obj_byte: expected %02h, got %02h", w.obj_byte, b);
			errors++;
		end
		if (f !== w.first) begin
			$error("obj_first: expected %0b, got %0b", w.first, f);
			errors++;
		end
		if (l !== w.last) begin
			$error("obj_last: expected %0b, got %0b", w.last, l);
			errors++;
		end
		if (t !== w.trunc) begin
			$error("obj_truncated: expected %0b, got %0b", w.trunc, t);
			errors++;
		end
	endfunction
endclass

module json_array_object_splitter_core_tb;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 12;
	localparam int WORD_TARGET = 950;      // words fed in total
	localparam int QUIET_AFTER = 800;      // from here on, no idling on either side
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;      // slack after the last result word
	localparam int CYCLE_LIMIT = 400000;

	// escapable / structural characters, packed; low four are braces and brackets
	localparam logic [47:0] STR_SPECIALS =
		{CH_QUOTE, CH_BSLASH, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_byte = 8'h00;
	logic       doc_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] obj_byte;
	logic       obj_first;
	logic       obj_last;
	logic       obj_truncated;

	splitter_scoreboard sb = new();

	// knobs shared between the stimulus thread and the receiver
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit long_hold = 1'b0;

	logic [7:0]  doc_q[$];   // bytes of the document being built
	int unsigned cycle_count = 0;

	always #CLK_HALF clk = ~clk;

	json_array_object_splitter_core #(
		.DEPTH_WIDTH(DEPTH_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_byte(char_byte),
		.doc_last(doc_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.obj_byte(obj_byte),
		.obj_first(obj_first),
		.obj_last(obj_last),
		.obj_truncated(obj_truncated)
	);

	// Both handshakes sampled at the edge; everything we drive changes via NBA,
	// so these see the values held over the cycle that just ended.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_word(char_byte, doc_last);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(obj_byte, obj_first, obj_last, obj_truncated);
	end

	// Watchdog: anything hanging ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold so the block backs up
	// all the way to in_stall while the sender keeps offering words.
	initial begin
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Appends one byte to the document being built.
	function automatic void put_byte(logic [7:0] b);
		doc_q = {doc_q, b};
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	// String with escapes, stray braces/brackets and high bytes inside it.
	function automatic void put_string();
		int n;
		n = $urandom_range(0, 5);
		put_byte(CH_QUOTE);
		repeat (n) begin
			case ($urandom_range(0, 7))
				0: begin
					put_byte(CH_BSLASH);
					put_byte(STR_SPECIALS[8 * $urandom_range(0, 5) +: 8]);
				end
				1: put_byte(STR_SPECIALS[8 * $urandom_range(0, 3) +: 8]);
				2: put_byte(8'($urandom_range(128, 255)));
				default: put_byte(8'($urandom_range(8'h61, 8'h7A)));
			endcase
		end
		put_byte(CH_QUOTE);
	endfunction

	function automatic void put_flat();
		case ($urandom_range(0, 3))
			0: put_string();
			1: repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(8'h30, 8'h39)));
			2: push_text("[1,2]");   // bracket close inside an object must not end the scan
			default: push_text("true");
		endcase
	endfunction

	// Object nested 1..3 deep, built flat (no recursion).
	function automatic void put_object();
		int levels;
		levels = $urandom_range(1, 3);
		for (int l = 0; l < levels; l++) begin
			put_byte(CH_LBRACE);
			repeat ($urandom_range(0, 2)) begin
				put_string();
				push_text(":");
				put_flat();
				push_text(",");
			end
			if (l != levels - 1) begin
				put_string();
				push_text(":");
			end
		end
		repeat (levels) begin
			if ($urandom_range(0, 1)) begin
				push_text(",");
				put_string();
				push_text(":");
				put_flat();
			end
			put_byte(CH_RBRACE);
		end
	endfunction

	// One word per handshake; valid stays up across back-to-back words.
	task automatic send_word(input logic [7:0] b, input logic is_last);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= b;
		doc_last <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Sends the built document; doc_last rides on its final byte.
	task automatic send_doc();
		for (int i = 0; i < doc_q.size(); i++)
			send_word(doc_q[i], i == doc_q.size() - 1);
		doc_q.delete();
	endtask

	// Sender goes quiet until every expected object word has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int doc_idx;
		int mode;
		int n_obj;
		int cut;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 1'b1;
		rx_idle = 1'b1;

		// Directed: a quote restarts the key match; escaped quote and a brace
		// inside a string; close at depth zero; stray close drives depth
		// negative so the next open brace does not start an object; bracket
		// close at depth zero ends the scan on the doc's last byte.
		push_text("\"\"data\"[{\"\\\"}\"}}{]");
		send_doc();
		// Directed: byte extremes inside an object, doc ends with it open.
		push_text("\"data\"[{");
		put_byte(8'hFF);
		put_byte(8'h00);
		send_doc();
		drain_results();

		doc_idx = 0;
		while (sb.accepted < WORD_TARGET) begin
			if (sb.accepted >= QUIET_AFTER) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end else begin
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
			end

			if (doc_idx == 2) begin
				// nesting past the positive limit, then back to zero; the
				// receiver holds off meanwhile so the pipe fills up
				long_hold = 1'b1;
				push_text("\"data\"[");
				repeat (DEPTH_HI + 4) put_byte(CH_LBRACE);
				repeat (DEPTH_HI) put_byte(CH_RBRACE);
				put_byte(CH_RBRACK);
			end else if (doc_idx == 4) begin
				// stray closes past the negative limit: nothing may come out
				push_text("\"data\"[");
				repeat (-DEPTH_LO + 3) put_byte(CH_RBRACE);
				repeat (3) put_byte(CH_LBRACE);
				push_text("\"x\"");
			end else begin
				// 0..5 well formed, 6 cut short, 7 noise sprinkled in,
				// 8 pure noise, 9 key missing
				mode = $urandom_range(0, 9);
				if (mode == 8) begin
					repeat ($urandom_range(1, 24)) put_byte(8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 3) == 0)
						push_text("\"dat");   // false start of the key
					if (mode != 9)
						push_text("\"data\"");
					push_text(": ");
					if ($urandom_range(0, 4) == 0)
						push_text("{x}");   // ignored while hunting for the bracket
					put_byte(CH_LBRACK);
					n_obj = $urandom_range(0, 4);
					for (int i = 0; i < n_obj; i++) begin
						if (i != 0)
							push_text(",");
						if ($urandom_range(0, 5) == 0) begin
							put_flat();   // bare value at depth zero, not emitted
							push_text(",");
						end
						put_object();
					end
					put_byte(CH_RBRACK);
					repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
					if (mode == 6) begin
						cut = $urandom_range(1, doc_q.size());
						while (doc_q.size() > cut)
							void'(doc_q.pop_back());
					end
					if (mode == 7)
						repeat ($urandom_range(1, 4))
							doc_q.insert($urandom_range(0, doc_q.size() - 1),
								8'($urandom_range(0, 255)));
				end
			end

			if (doc_idx == 6)
				drain_results();
			send_doc();
			doc_idx++;
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
